/* rtl/iprt_pkg.sv */
// Shared types, constants and helpers of the IPv4 range table lookup.
package iprt_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 65536;

  localparam int unsigned CFG_W     = 17;
  localparam int unsigned IDX_IN_W  = 16;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned LOC_W     = 32;
  localparam int unsigned IN_DATA_W = 112;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_LOC    = 3'b100
  } eng_state_t;

  // Control from the top level to the search engine.
  typedef struct packed {
    logic start;
    logic load;
    logic take;
  } eng_ctl_t;

  // Status from the search engine.
  typedef struct packed {
    logic idle;
    logic done;
  } eng_sts_t;

  function automatic logic [ADDR_W-1:0] swap_bytes(input logic [ADDR_W-1:0] v);
    swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

/* rtl/ip_range_table_lookup_unit.sv */
// Top level of the IPv4 range table lookup: stream ports, count register and result register.
//
// The block holds a table of IPv4 ranges sorted by inclusive upper address, each with a
// 32-bit location code, and finds for a lookup address the first range whose end is at or
// above it, searching the first entry_count-1 entries and falling back to the last one.
// A load transfer writes one entry into both memories. A lookup transfer issues the first
// midpoint read at its own edge and then performs the binary-search steps, whose number is at
// most the bit length of entry_count-1 (sixteen for a full table of 65536 entries); the last
// step also reads the location code, and the result then moves into the output register as
// soon as that register is free. The input reopens at the same edge at which the result
// reaches the output register. The pace is set by the range-end memory, whose single read
// port serves one midpoint per cycle and whose data decides the next address. The next
// item is taken as soon as the result has moved to the output register. The tables have
// no reset and need no clearing pass; only entries that have been loaded may be searched.
module ip_range_table_lookup_unit import iprt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,  // entry_count
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index[15:0], range_end[47:16], location_code[79:48], ip_address[111:80]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[0], network_order[1]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // found_index[15:0], found_location[47:16]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CMP_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

  logic [CFG_W-1:0]      entry_count_r;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [IDX_IN_W-1:0]   entry_index;
  logic [ADDR_W-1:0]     range_end, ip_address, lookup_addr;
  logic [LOC_W-1:0]      location_code;
  mode_t                 mode;
  logic                  network_order;
  logic                  in_acc;

  logic [CMP_W-1:0]      cnt_ext, eff_cnt, len_full, idx_ext, found_ext;
  logic                  idx_ok;

  eng_ctl_t              ctl;
  eng_sts_t              sts;
  logic [IDX_W-1:0]      found_idx;
  logic [LOC_W-1:0]      found_loc;

  assign entry_index   = in_tdata[15:0];
  assign range_end     = in_tdata[47:16];
  assign location_code = in_tdata[79:48];
  assign ip_address    = in_tdata[111:80];
  assign mode          = mode_t'(in_tuser[0]);
  assign network_order = in_tuser[1];

  assign in_tready = sts.idle;
  assign in_acc    = in_tvalid && in_tready;

  assign lookup_addr = network_order ? swap_bytes(ip_address) : ip_address;

  // A count of zero searches nothing; a count beyond the table saturates.
  always_comb begin
    cnt_ext = CMP_W'(entry_count_r);
    if (cnt_ext == '0) begin
      eff_cnt = CMP_W'(1);
    end else if (cnt_ext > CMP_W'(TABLE_DEPTH)) begin
      eff_cnt = CMP_W'(TABLE_DEPTH);
    end else begin
      eff_cnt = cnt_ext;
    end
    len_full = eff_cnt - CMP_W'(1);
  end

  // Loads aimed beyond the table are dropped.
  assign idx_ext = CMP_W'(entry_index);
  assign idx_ok  = idx_ext < CMP_W'(TABLE_DEPTH);

  assign ctl.start = in_acc && (mode == MODE_LOOKUP);
  assign ctl.load  = in_acc && (mode == MODE_LOAD) && idx_ok;
  assign ctl.take  = sts.done && (!out_tvalid_r || out_tready);

  iprt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .load_idx    (idx_ext[IDX_W-1:0]),
    .load_end    (range_end),
    .load_loc    (location_code),
    .lookup_addr (lookup_addr),
    .search_len  (len_full[IDX_W-1:0]),
    .sts         (sts),
    .found_idx   (found_idx),
    .found_loc   (found_loc)
  );

  assign found_ext = CMP_W'(found_idx);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (ctl.take) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= CFG_W'(1);
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        entry_count_r <= cfg_wr_data;
      end
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      out_tdata_r <= {found_loc, found_ext[IDX_IN_W-1:0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A lookup transfer closes the input until its search has finished.
  a_lookup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == MODE_LOOKUP) |=> !in_tready)
    else $error("input still open after a lookup transfer");

  // A load transfer leaves the input open for the next item.
  a_load_keeps_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == MODE_LOAD) |=> in_tready)
    else $error("input closed after a load transfer");

  // A new result only appears when the engine had one finished.
  a_result_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(sts.done))
    else $error("result appeared without a finished search");

endmodule

/* rtl/iprt_engine.sv */
// Range table memories and the sequencer that binary-searches them.
module iprt_engine import iprt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned IDX_W       = $clog2(DEF_TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  eng_ctl_t          ctl,
  input  logic [IDX_W-1:0]  load_idx,
  input  logic [ADDR_W-1:0] load_end,
  input  logic [LOC_W-1:0]  load_loc,
  input  logic [ADDR_W-1:0] lookup_addr,
  input  logic [IDX_W-1:0]  search_len,
  output eng_sts_t          sts,
  output logic [IDX_W-1:0]  found_idx,
  output logic [LOC_W-1:0]  found_loc
);

  logic [ADDR_W-1:0] end_mem [TABLE_DEPTH];
  logic [LOC_W-1:0]  loc_mem [TABLE_DEPTH];

  eng_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  first_r, first_nxt;
  logic [IDX_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  half_r, half_nxt;
  logic [IDX_W-1:0]  mid_r, mid_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] end_rd_r;
  logic [LOC_W-1:0]  loc_rd_r;
  logic              end_rd_en, loc_rd_en;
  logic [IDX_W-1:0]  base_first, base_count;
  logic              run;

  always_comb begin
    state_nxt  = state_r;
    base_first = first_r;
    base_count = count_r;
    run        = 1'b0;
    end_rd_en  = 1'b0;
    loc_rd_en  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        base_first = '0;
        base_count = search_len;
        run        = ctl.start;
      end
      ST_SEARCH: begin
        run = 1'b1;
        // The range end at the previous midpoint arrived this cycle.
        if (end_rd_r < addr_r) begin
          base_first = mid_r + IDX_W'(1);
          base_count = count_r - half_r - IDX_W'(1);
        end else begin
          base_first = first_r;
          base_count = half_r;
        end
      end
      ST_LOC: begin
        if (ctl.take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    first_nxt = base_first;
    count_nxt = base_count;
    half_nxt  = base_count >> 1;
    mid_nxt   = base_first + (base_count >> 1);
    if (run) begin
      if (base_count != '0) begin
        end_rd_en = 1'b1;
        state_nxt = ST_SEARCH;
      end else begin
        loc_rd_en = 1'b1;
        state_nxt = ST_LOC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      first_r <= first_nxt;
      count_r <= count_nxt;
      half_r  <= half_nxt;
      mid_r   <= mid_nxt;
    end
    if (state_r == ST_IDLE && ctl.start) begin
      addr_r <= lookup_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      end_mem[load_idx] <= load_end;
    end
  end

  always_ff @(posedge clk) begin
    if (end_rd_en) begin
      end_rd_r <= end_mem[mid_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      loc_mem[load_idx] <= load_loc;
    end
  end

  always_ff @(posedge clk) begin
    if (loc_rd_en) begin
      loc_rd_r <= loc_mem[first_nxt];
    end
  end

  assign sts.idle  = (state_r == ST_IDLE);
  assign sts.done  = (state_r == ST_LOC);
  assign found_idx = first_r;
  assign found_loc = loc_rd_r;

endmodule
